@@ design/bitmap_block_run_allocator_top_defines.svh @@
// Assertion macros used by the allocator RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef BITMAP_BLOCK_RUN_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_RUN_ALLOCATOR_TOP_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define BBRA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define BBRA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ design/bbra_pkg.sv @@
package bbra_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int MAX_RUN    = 16;
	localparam int WORD_BITS  = 64;
	localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;

	localparam int IDX_W     = 12;
	localparam int LIMIT_W   = 13;
	localparam int WORD_W    = $clog2(MAP_WORDS);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int RUN_W     = $clog2(MAX_RUN + 1);
	localparam int RUN_IDX_W = $clog2(MAX_RUN);

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_MARK  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BAD     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FM,
		S_RD,
		S_CHK,
		S_RB_RL,
		S_RB_MAP,
		S_RB_WR,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [6:0]       blocks_needed;
		logic [4:0]       blocks_held;
		logic [IDX_W-1:0] target_blk;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] alloc_blk;
		logic             has_block;
		status_t          status;
		logic             last;
	} result_t;

endpackage

@@ design/bitmap_block_run_allocator_top.sv @@
// First-fit free-block bitmap allocator, one used bit per data block.
// Command channel: a beat on cmd is taken at a rising edge with start high and busy low.
// Mode allocate takes blocks_needed - blocks_held blocks, always the lowest free block
// below the limit, and reports each as one result beat in the order taken. If space
// runs out, every block of that request is freed again and one no-space beat is given.
// Mode free clears one bit and mode mark sets one bit; each gives one result beat.
// Result channel: every beat is on result for exactly one cycle with strobe high, and
// last marks the final beat of a command. The receiver cannot hold results off.
// Configuration: cfg_data is written into the block limit whenever cfg_valid is high;
// cfg_ready is always high. Write it only while the block is idle.
// Sequence: rejected and empty requests have their beat registered at the accept itself,
// free and mark in state S_FM, which also writes the bitmap word back. An allocation is
// paced by the bitmap memory's one read port: each bitmap word visited passes S_RD (read),
// then S_CHK (check and write back), and each extra block found in a word passes both
// again; then come the result beats, one per cycle. A rollback passes S_RB_RL, S_RB_MAP
// and S_RB_WR for each block already taken.
// Throughput: busy stays high until the last beat is registered, so the next command
// can be taken at the edge that ends the last beat of the one before.
// Reset clears the whole map at once through one valid bit per bitmap word, so the
// block takes commands as soon as reset is released; the limit resets to 4096.

`include "bitmap_block_run_allocator_top_defines.svh"

module bitmap_block_run_allocator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  bbra_pkg::cmd_t                  cmd,
	output logic                            strobe,
	output bbra_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bbra_pkg::LIMIT_W-1:0]    cfg_data
);

	import bbra_pkg::*;

	state_t state_q, state_d;

	logic [LIMIT_W-1:0]   limit_q;
	logic [LIMIT_W-1:0]   eff_lim;
	logic [MAP_WORDS-1:0] valid_q;

	logic [RUN_W-1:0]     n_q, cnt_q, j_q;
	logic [WORD_W-1:0]    w_q;
	logic [BIT_W-1:0]     bit_q;
	logic                 mark_q;

	// Map memory port signals.
	logic [WORD_W-1:0]    map_raddr, map_waddr, rd_w_s1;
	logic                 map_we;
	logic [WORD_BITS-1:0] map_wdata, map_rdata, word_data;

	// Run list memory port signals.
	logic [RUN_IDX_W-1:0] rl_raddr, rl_waddr;
	logic                 rl_we;
	logic [IDX_W-1:0]     rl_wdata, rl_rdata;

	// Search over one bitmap word.
	logic [WORD_BITS-1:0] allow, avail;
	logic                 found;
	logic [BIT_W-1:0]     pos;
	logic                 more_words;

	// Command decode at accept.
	logic                 accept;
	logic                 too_long, nothing, bad_idx;

	// Result register load.
	logic                 emit;
	result_t              emit_res, res_q;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign eff_lim = (limit_q > LIMIT_W'(MAX_BLOCKS)) ? LIMIT_W'(MAX_BLOCKS) : limit_q;

	assign too_long = (cmd.blocks_needed > 7'(MAX_RUN));
	assign nothing  = (cmd.blocks_needed <= 7'(cmd.blocks_held));
	assign bad_idx  = ({1'b0, cmd.target_blk} >= eff_lim);

	// A word never written since reset reads as all free.
	assign word_data = valid_q[rd_w_s1] ? map_rdata : '0;

	// Blocks at or above the limit count as unavailable in the word under check.
	always_comb begin
		if ({1'b0, w_q} < eff_lim[LIMIT_W-1:BIT_W]) begin
			allow = '1;
		end else if ({1'b0, w_q} == eff_lim[LIMIT_W-1:BIT_W]) begin
			allow = (WORD_BITS'(1) << eff_lim[BIT_W-1:0]) - WORD_BITS'(1);
		end else begin
			allow = '0;
		end
	end

	assign avail = ~word_data & allow;
	assign found = |avail;

	always_comb begin
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				pos = BIT_W'(i);
			end
		end
	end

	assign more_words = ({(WORD_W + 1)'({1'b0, w_q} + 1'b1), {BIT_W{1'b0}}} < eff_lim);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd.mode == MODE_ALLOC) begin
						if (!too_long && !nothing) begin
							state_d = S_RD;
						end
					end else if (cmd.mode == MODE_FREE || cmd.mode == MODE_MARK) begin
						if (!bad_idx) begin
							state_d = S_FM;
						end
					end
				end
			end
			S_FM: state_d = S_IDLE;
			S_RD: state_d = S_CHK;
			S_CHK: begin
				if (found) begin
					state_d = (RUN_W'(cnt_q + 1'b1) == n_q) ? S_EMIT : S_RD;
				end else if (more_words) begin
					state_d = S_RD;
				end else begin
					state_d = (cnt_q == '0) ? S_IDLE : S_RB_RL;
				end
			end
			S_RB_RL:  state_d = S_RB_MAP;
			S_RB_MAP: state_d = S_RB_WR;
			S_RB_WR:  state_d = (RUN_W'(j_q + 1'b1) == cnt_q) ? S_IDLE : S_RB_RL;
			S_EMIT:   state_d = (RUN_W'(j_q + 1'b1) == n_q) ? S_IDLE : S_EMIT;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory controls and result loads.
	always_comb begin
		map_raddr = w_q;
		map_waddr = rd_w_s1;
		map_we    = 1'b0;
		map_wdata = word_data;
		rl_raddr  = j_q[RUN_IDX_W-1:0];
		rl_waddr  = cnt_q[RUN_IDX_W-1:0];
		rl_we     = 1'b0;
		rl_wdata  = {w_q, pos};
		emit      = 1'b0;
		emit_res  = '{alloc_blk: '0, has_block: 1'b0, status: ST_OK, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				map_raddr = cmd.target_blk[IDX_W-1:BIT_W];
				if (accept) begin
					if (cmd.mode == MODE_ALLOC) begin
						if (too_long) begin
							emit            = 1'b1;
							emit_res.status = ST_BAD;
						end else if (nothing) begin
							emit = 1'b1;
						end
					end else if (cmd.mode == MODE_FREE || cmd.mode == MODE_MARK) begin
						if (bad_idx) begin
							emit            = 1'b1;
							emit_res.status = ST_BAD;
						end
					end else begin
						emit            = 1'b1;
						emit_res.status = ST_BAD;
					end
				end
			end
			S_FM: begin
				map_we = 1'b1;
				if (mark_q) begin
					map_wdata = word_data | (WORD_BITS'(1) << bit_q);
				end else begin
					map_wdata = word_data & ~(WORD_BITS'(1) << bit_q);
				end
				emit = 1'b1;
			end
			S_RD: begin
			end
			S_CHK: begin
				if (found) begin
					map_we    = 1'b1;
					map_wdata = word_data | (WORD_BITS'(1) << pos);
					rl_we     = 1'b1;
				end else if (!more_words && cnt_q == '0) begin
					emit            = 1'b1;
					emit_res.status = ST_NOSPACE;
				end
			end
			S_RB_RL: begin
			end
			S_RB_MAP: begin
				map_raddr = rl_rdata[IDX_W-1:BIT_W];
			end
			S_RB_WR: begin
				map_we    = 1'b1;
				map_wdata = word_data & ~(WORD_BITS'(1) << bit_q);
				if (RUN_W'(j_q + 1'b1) == cnt_q) begin
					emit            = 1'b1;
					emit_res.status = ST_NOSPACE;
				end
			end
			S_EMIT: begin
				emit               = 1'b1;
				emit_res.has_block = 1'b1;
				emit_res.last      = (RUN_W'(j_q + 1'b1) == n_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= LIMIT_W'(MAX_BLOCKS);
			valid_q <= '0;
			strobe  <= 1'b0;
			n_q     <= '0;
			cnt_q   <= '0;
			j_q     <= '0;
			w_q     <= '0;
		end else begin
			state_q <= state_d;
			strobe  <= emit;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (map_we) begin
				valid_q[map_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					n_q   <= RUN_W'(cmd.blocks_needed - 7'(cmd.blocks_held));
					cnt_q <= '0;
					j_q   <= '0;
					w_q   <= '0;
				end
				S_CHK: begin
					if (found) begin
						cnt_q <= RUN_W'(cnt_q + 1'b1);
					end else if (more_words) begin
						w_q <= WORD_W'(w_q + 1'b1);
					end
				end
				S_RB_WR, S_EMIT: begin
					j_q <= RUN_W'(j_q + 1'b1);
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_w_s1 <= map_raddr;
		if (emit) begin
			res_q <= emit_res;
		end
		if (state_q == S_IDLE) begin
			bit_q  <= cmd.target_blk[BIT_W-1:0];
			mark_q <= (cmd.mode == MODE_MARK);
		end else if (state_q == S_RB_MAP) begin
			bit_q <= rl_rdata[BIT_W-1:0];
		end
	end

	// Block indexes come straight from the run list read register.
	assign result = '{
		alloc_blk: res_q.has_block ? rl_rdata : '0,
		has_block: res_q.has_block,
		status:    res_q.status,
		last:      res_q.last
	};

	bbra_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	bbra_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_RUN)
	) u_run_ram (
		.clk  (clk),
		.we   (rl_we),
		.waddr(rl_waddr),
		.wdata(rl_wdata),
		.raddr(rl_raddr),
		.rdata(rl_rdata)
	);

	`BBRA_ASSERT(a_run_beats_contiguous, strobe && !result.last |=> strobe, "allocation beats broke up")
	`BBRA_ASSERT(a_block_only_ok, strobe && result.has_block |-> result.status == ST_OK, "block with bad status")
	`BBRA_ASSERT_NEVER(a_run_overflow, state_q == S_CHK && cnt_q >= n_q, "run count passed request")
	`BBRA_ASSERT(a_rollback_bound, (state_q == S_RB_RL || state_q == S_RB_MAP || state_q == S_RB_WR) |-> j_q < cnt_q, "rollback past run")
	`BBRA_ASSERT_NEVER(a_idle_write, state_q == S_IDLE && (map_we || rl_we), "memory write while idle")

endmodule

@@ design/bbra_ram.sv @@
module bbra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; a read of the address written at the same edge returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
